[design/stsc_pkg.sv]
package stsc_pkg;

  // one-hot phase of the reply scan
  typedef enum logic [2:0] {
    PH_RESP  = 3'b001,
    PH_SLOT  = 3'b010,
    PH_CKSUM = 3'b100
  } stsc_phase_e;

  // configuration register indexes
  localparam logic [0:0] REG_SLOT_COUNT = 1'b0;
  localparam logic [0:0] REG_SLOT_BYTES = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CKSUM = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;

  localparam logic [7:0] SLOT_COUNT_RST = 8'd128;
  localparam logic [4:0] SLOT_BYTES_RST = 5'd8;
  localparam logic [4:0] SLOT_BYTES_MIN = 5'd2;
  localparam logic [7:0] FREE_MARK      = 8'hFF;

  typedef struct packed {
    logic [6:0] free_slot;
    logic [1:0] status;
    logic [7:0] used_slots;
  } stsc_res_t;

  typedef struct packed {
    logic res_valid;
    logic in_cksum;
  } stsc_ctl_t;

endpackage

[design/stsc_core.sv]
module stsc_core import stsc_pkg::*; #(
  parameter int MAX_SLOTS      = 128,
  parameter int MAX_SLOT_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic       restart_i,
  output stsc_res_t  res_o,
  output stsc_ctl_t  ctl_o
);

  localparam logic [7:0] MaxCount = 8'(MAX_SLOTS);
  localparam logic [4:0] MaxBytes = 5'(MAX_SLOT_BYTES);

  logic [7:0]  slot_count_q;
  logic [4:0]  slot_bytes_q;
  stsc_phase_e phase_q, phase_d;
  logic [7:0]  slot_index_q, slot_index_d;
  logic [3:0]  byte_index_q, byte_index_d;
  logic [7:0]  sum_q, sum_d;
  logic [6:0]  first_free_q, first_free_d;
  logic        free_found_q, free_found_d;
  logic [7:0]  occupied_q, occupied_d;

  logic [7:0]  eff_count;
  logic [4:0]  eff_bytes;
  logic [7:0]  slot_inc;
  logic        start;
  logic        end_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      slot_bytes_q <= SLOT_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLOT_COUNT: slot_count_q <= cfg_data_i;
        REG_SLOT_BYTES: slot_bytes_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign eff_count = (slot_count_q > MaxCount) ? MaxCount : slot_count_q;
  assign eff_bytes = (slot_bytes_q < SLOT_BYTES_MIN) ? SLOT_BYTES_MIN :
                     (slot_bytes_q > MaxBytes) ? MaxBytes : slot_bytes_q;
  assign slot_inc  = slot_index_q + 8'd1;
  assign start     = restart_i || !(phase_q == PH_SLOT || phase_q == PH_CKSUM);

  always_comb begin
    phase_d      = phase_q;
    slot_index_d = slot_index_q;
    byte_index_d = byte_index_q;
    sum_d        = sum_q;
    first_free_d = first_free_q;
    free_found_d = free_found_q;
    occupied_d   = occupied_q;
    end_slot     = 1'b0;
    ctl_o.res_valid  = 1'b0;
    ctl_o.in_cksum   = (phase_q == PH_CKSUM);
    res_o.free_slot  = free_found_q ? first_free_q : 7'd0;
    res_o.used_slots = occupied_q;
    if (occupied_q != 8'd0 && sum_q != rx_byte_i) begin
      res_o.status = ST_BAD_CKSUM;
    end else if (!free_found_q) begin
      res_o.status = ST_NO_FREE;
    end else begin
      res_o.status = ST_OK;
    end

    if (step_i) begin
      priority if (start) begin
        slot_index_d = 8'd0;
        byte_index_d = 4'd0;
        sum_d        = 8'd0;
        first_free_d = 7'd0;
        free_found_d = 1'b0;
        occupied_d   = 8'd0;
        phase_d      = (eff_count == 8'd0) ? PH_CKSUM : PH_SLOT;
      end else if (phase_q == PH_SLOT) begin
        if (byte_index_q == 4'd0) begin
          if (rx_byte_i == FREE_MARK) begin
            if (!free_found_q) begin
              first_free_d = slot_index_q[6:0];
              free_found_d = 1'b1;
            end
            end_slot = 1'b1;
          end else begin
            // first byte of an occupied slot; slot is at least two bytes
            sum_d        = sum_q + rx_byte_i;
            occupied_d   = occupied_q + 8'd1;
            byte_index_d = 4'd1;
          end
        end else begin
          sum_d = sum_q + rx_byte_i;
          if ({1'b0, byte_index_q} + 5'd1 >= eff_bytes) begin
            end_slot = 1'b1;
          end else begin
            byte_index_d = byte_index_q + 4'd1;
          end
        end
        if (end_slot) begin
          byte_index_d = 4'd0;
          slot_index_d = slot_inc;
          if (slot_inc >= eff_count) begin
            phase_d = PH_CKSUM;
          end
        end
      end else begin
        // checksum byte closes the reply
        ctl_o.res_valid = 1'b1;
        phase_d         = PH_RESP;
        slot_index_d    = 8'd0;
        byte_index_d    = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_RESP;
      slot_index_q <= 8'd0;
      byte_index_q <= 4'd0;
      sum_q        <= 8'd0;
      first_free_q <= 7'd0;
      free_found_q <= 1'b0;
      occupied_q   <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      slot_index_q <= slot_index_d;
      byte_index_q <= byte_index_d;
      sum_q        <= sum_d;
      first_free_q <= first_free_d;
      free_found_q <= free_found_d;
      occupied_q   <= occupied_d;
    end
  end

endmodule

[design/stsc_out_reg.sv]
module stsc_out_reg import stsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  stsc_res_t res_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output stsc_res_t res_o
);

  logic      valid_q, valid_d;
  stsc_res_t res_q;

  // free or being drained this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[design/slot_table_reply_scanner.sv]
// Scans a slot-table upload reply one byte per item and takes a new item on every
// clock cycle while in_ready_o is high. The first byte (or any byte with restart
// set) opens a reply; a result appears on the output in the cycle after the
// checksum byte is accepted, held in a single result register. in_ready_o drops
// only while that register holds a result the consumer has not taken.
// Configuration writes take effect on the next byte.
module slot_table_reply_scanner import stsc_pkg::*; #(
  parameter int MAX_SLOTS      = 128,
  parameter int MAX_SLOT_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] free_slot_o,
  output logic [1:0] status_o,
  output logic [7:0] used_slots_o
);

  logic      step;
  stsc_res_t core_res;
  stsc_ctl_t core_ctl;
  stsc_res_t out_res;

  assign step = in_valid_i && in_ready_o;

  stsc_core #(
    .MAX_SLOTS      (MAX_SLOTS),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .rx_byte_i  (rx_byte_i),
    .restart_i  (restart_i),
    .res_o      (core_res),
    .ctl_o      (core_ctl)
  );

  stsc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (core_ctl.res_valid),
    .res_i       (core_res),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign free_slot_o  = out_res.free_slot;
  assign status_o     = out_res.status;
  assign used_slots_o = out_res.used_slots;

`ifndef SYNTHESIS
  a_checksum_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && core_ctl.in_cksum && !restart_i |=> out_valid_o)
    else $error("checksum item gave no result");

  a_result_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.res_valid |-> in_ready_o)
    else $error("result loaded into a full register");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({24'd0, used_slots_o} <= 32'(MAX_SLOTS)))
    else $error("occupied count above slot limit");

  a_no_free_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_FREE |-> free_slot_o == 7'd0)
    else $error("free index reported without a free slot");
`endif

endmodule

[sim/slot_table_reply_scanner_tb.sv]
import stsc_pkg::*;

class reply_scoreboard;
  localparam int MAX_SLOTS      = 128;
  localparam int MAX_SLOT_BYTES = 16;

  logic [7:0]  count_reg;
  logic [4:0]  len_reg;

  stsc_phase_e scan_phase;
  logic [7:0]  slot_idx;
  logic [3:0]  byte_idx;
  logic [7:0]  run_sum;
  logic [6:0]  first_free;
  logic        free_found;
  logic [7:0]  occupied;

  stsc_res_t   expected_summaries[$];
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_errors;

  function new();
    count_reg  = SLOT_COUNT_RST;
    len_reg    = SLOT_BYTES_RST;
    scan_phase = PH_RESP;
    slot_idx   = '0;
    byte_idx   = '0;
    run_sum    = '0;
    first_free = '0;
    free_found = 1'b0;
    occupied   = '0;
    n_items    = 0;
    n_results  = 0;
    n_errors   = 0;
  endfunction

  function int table_slots();
    return (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
  endfunction

  function int record_len();
    if (len_reg < SLOT_BYTES_MIN) return int'(SLOT_BYTES_MIN);
    if (len_reg > MAX_SLOT_BYTES) return MAX_SLOT_BYTES;
    return int'(len_reg);
  endfunction

  function int pending();
    return expected_summaries.size();
  endfunction

  function void write_reg(logic [0:0] idx, logic [7:0] data);
    case (idx)
      REG_SLOT_COUNT: count_reg = data;
      REG_SLOT_BYTES: len_reg = data[4:0];
      default: ;
    endcase
  endfunction

  function void open_reply();
    slot_idx   = '0;
    byte_idx   = '0;
    run_sum    = '0;
    first_free = '0;
    free_found = 1'b0;
    occupied   = '0;
    scan_phase = (table_slots() == 0) ? PH_CKSUM : PH_SLOT;
  endfunction

  function void advance_slot();
    byte_idx = '0;
    slot_idx = slot_idx + 8'd1;
    if (int'(slot_idx) >= table_slots()) scan_phase = PH_CKSUM;
  endfunction

  function void note_byte(logic [7:0] b, logic restart);
    stsc_res_t res;
    n_items++;
    if (restart || (scan_phase != PH_SLOT && scan_phase != PH_CKSUM)) begin
      open_reply();
      return;
    end
    if (scan_phase == PH_SLOT) begin
      if (byte_idx == 0 && b == FREE_MARK) begin
        if (!free_found) begin
          first_free = slot_idx[6:0];
          free_found = 1'b1;
        end
        advance_slot();
      end else begin
        run_sum = run_sum + b;
        if (byte_idx == 0) occupied = occupied + 8'd1;
        if (int'(byte_idx) + 1 >= record_len()) advance_slot();
        else byte_idx = byte_idx + 4'd1;
      end
      return;
    end
    // checksum byte closes the reply
    res.free_slot  = free_found ? first_free : 7'd0;
    res.used_slots = occupied;
    if (occupied != 0 && run_sum != b) res.status = ST_BAD_CKSUM;
    else if (!free_found) res.status = ST_NO_FREE;
    else res.status = ST_OK;
    expected_summaries.push_back(res);
    scan_phase = PH_RESP;
    slot_idx   = '0;
    byte_idx   = '0;
  endfunction

  task report(string msg);
    n_errors++;
    if (n_errors <= 200) $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_result(logic [6:0] free_slot, logic [1:0] status, logic [7:0] used_slots);
    stsc_res_t want;
    n_results++;
    if (expected_summaries.size() == 0) begin
      report($sformatf("unexpected result free %0d status %0d used %0d",
                       free_slot, status, used_slots));
      return;
    end
    want = expected_summaries.pop_front();
    if (free_slot !== want.free_slot)
      report($sformatf("free_slot %0d, want %0d", free_slot, want.free_slot));
    if (status !== want.status)
      report($sformatf("status %0d, want %0d", status, want.status));
    if (used_slots !== want.used_slots)
      report($sformatf("used_slots %0d, want %0d", used_slots, want.used_slots));
  endtask
endclass

module slot_table_reply_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS      = 128;
  localparam int MAX_SLOT_BYTES = 16;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [0:0] cfg_idx_i   = REG_SLOT_COUNT;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = '0;
  logic       restart_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [6:0] free_slot_o;
  logic [1:0] status_o;
  logic [7:0] used_slots_o;

  reply_scoreboard sb = new();

  int unsigned burst_left;
  bit          gaps_on;
  bit          framed;
  int          gen_slots;
  int          gen_len;

  ready_mode_e ready_mode;
  int unsigned mode_left;
  int unsigned cycle_cnt;

  logic [7:0] fixed_count [7] = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd129, 8'd3, 8'd2};
  logic [7:0] fixed_bytes [7] = '{8'h00, 8'h01, 8'hE2, 8'h10, 8'h3C, 8'h6F, 8'h11};

  slot_table_reply_scanner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .free_slot_o (free_slot_o),
    .status_o    (status_o),
    .used_slots_o(used_slots_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver switches at random between stall patterns
  initial begin
    ready_mode = RDY_ALWAYS;
    mode_left  = 0;
    cycle_cnt  = 0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 80);
    end else begin
      mode_left = mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:   out_ready_i <= 1'b1;
      RDY_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:      out_ready_i <= (cycle_cnt % 8 < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(free_slot_o, status_o, used_slots_o);
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_byte(rx_byte_i, restart_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left = burst_left - 1;
    rx_byte_i  <= b;
    restart_i  <= restart;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes both registers back to back; sender must be idle
  task automatic set_table(input logic [7:0] count, input logic [7:0] bytes);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SLOT_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SLOT_BYTES;
    cfg_data_i <= bytes;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gen_slots = (count > MAX_SLOTS) ? MAX_SLOTS : int'(count);
    if (bytes[4:0] < SLOT_BYTES_MIN) gen_len = int'(SLOT_BYTES_MIN);
    else if (bytes[4:0] > MAX_SLOT_BYTES) gen_len = MAX_SLOT_BYTES;
    else gen_len = int'(bytes[4:0]);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
    framed = 1'b0;
  endtask

  task automatic send_reply(input int unsigned occ_pct, input bit cut_short);
    logic [7:0]  run_sum;
    logic [7:0]  b;
    int          stop_at;
    bit          good;
    run_sum = '0;
    stop_at = cut_short ? int'($urandom_range(0, gen_slots)) : gen_slots + 1;
    good    = ($urandom_range(0, 3) != 0);
    send_byte(8'($urandom_range(0, 255)), !framed || $urandom_range(0, 1));
    framed = 1'b0;
    for (int s = 0; s < gen_slots; s++) begin
      if (s == stop_at) return;
      if ($urandom_range(1, 100) > occ_pct) begin
        send_byte(FREE_MARK, 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0:       b = 8'hFE;
          1:       b = 8'h00;
          default: b = 8'($urandom_range(0, 254));
        endcase
        run_sum = run_sum + b;
        send_byte(b, 1'b0);
        for (int k = 1; k < gen_len; k++) begin
          b = 8'($urandom_range(0, 255));
          run_sum = run_sum + b;
          send_byte(b, 1'b0);
        end
      end
    end
    if (cut_short) return;
    send_byte(good ? run_sum : run_sum ^ 8'($urandom_range(1, 255)), 1'b0);
    framed = 1'b1;
  endtask

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned occ;
    int unsigned n_rep;
    logic [7:0]  count;
    logic [7:0]  bytes;
    burst_left = 0;
    gaps_on    = 1'b1;
    framed     = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed replies with two slots of two bytes
    set_table(8'd2, 8'd2);
    // occupied then free, checksum good
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // all free: checksum not compared
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    // all occupied, sum wraps, checksum good
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h81, 1'b0);
    // bad checksum wins over no free slot
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h0B, 1'b0);
    // restart inside a slot, then again on the checksum byte
    send_byte(8'h55, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    framed = 1'b0;

    for (int p = 0; p < 400; p++) begin
      if (p >= 7 && sb.n_items >= 1300 && sb.n_results >= 40) break;
      stop_sending();
      wait_drain();
      if (p < 7) begin
        count = fixed_count[p];
        bytes = fixed_bytes[p];
      end else begin
        count = 8'($urandom_range(1, 8));
        bytes = 8'($urandom_range(0, 255));
      end
      set_table(count, bytes);
      gaps_on = ($urandom_range(0, 3) != 0);
      // reply left open by the last phase continues under the new table
      if (!framed) send_noise($urandom_range(1, 20));
      n_rep = (gen_slots > 16) ? 1 : $urandom_range(3, 8);
      repeat (n_rep) begin
        if (gen_slots > 16) begin
          occ = 5;
        end else begin
          case ($urandom_range(0, 3))
            0:       occ = 0;
            1:       occ = 35;
            2:       occ = 65;
            default: occ = 100;
          endcase
        end
        case ($urandom_range(0, 9))
          0:       send_noise($urandom_range(1, 6));
          1:       send_reply(occ, 1'b1);
          default: send_reply(occ, 1'b0);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          stop_sending();
          wait_drain();
        end
      end
      if ($urandom_range(0, 3) == 0) send_reply((gen_slots > 16) ? 5 : 50, 1'b1);
    end

    stop_sending();
    wait_drain();
    if (sb.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
design/stsc_pkg.sv
design/stsc_core.sv
design/stsc_out_reg.sv
design/slot_table_reply_scanner.sv
sim/slot_table_reply_scanner_tb.sv
